// ===== hw/rtl/blop_pkg.sv =====
package blop_pkg;
    localparam int MaxSteps = 128;
    localparam int IdxW = $clog2(MaxSteps + 1);
    localparam int StepW = 8;

    localparam logic [2:0] RegStrike = 3'd0;
    localparam logic [2:0] RegDown   = 3'd1;
    localparam logic [2:0] RegUpSq   = 3'd2;
    localparam logic [2:0] RegWu     = 3'd3;
    localparam logic [2:0] RegWd     = 3'd4;
    localparam logic [2:0] RegSteps  = 3'd5;
    localparam logic [2:0] RegCall   = 3'd6;
    localparam logic [2:0] RegAmer   = 3'd7;

    typedef enum logic [3:0] {
        t_IDLE, t_DN_RD, t_DN_MUL, t_TM_RD, t_TM_MUL,
        t_BK_RD, t_BK_MUL, t_BK_SUM, t_BK_WR, t_DONE
    } t_state;

    typedef struct packed {
        logic            load_spot;
        logic            dn_step;
        logic            tm_start;
        logic            tm_step;
        logic            bk_row;
        logic            mul_price;
        logic            mul_wt;
        logic            bk_write;
        logic            done;
        logic [IdxW-1:0] idx;
        logic [IdxW-1:0] row;
    } t_cmd;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction
endpackage

// ===== hw/rtl/blop_ctrl.sv =====
module blop_ctrl import blop_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_busy,
    input  logic [StepW-1:0] i_steps,
    output logic            o_in_stall,
    output t_cmd            o_cmd
);
    t_state r_state, n_state;
    logic [IdxW-1:0] r_i, n_i, r_j, n_j, r_n, n_n;
    logic [IdxW-1:0] w_n;

    always_comb begin
        if (i_steps == '0) w_n = IdxW'(1);
        else if ({1'b0, i_steps} > (StepW+1)'(MaxSteps)) w_n = IdxW'(MaxSteps);
        else w_n = IdxW'(i_steps);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_IDLE;
            r_i <= '0; r_j <= '0; r_n <= '0;
        end else begin
            r_state <= n_state;
            r_i <= n_i; r_j <= n_j; r_n <= n_n;
        end
    end

    always_comb begin
        n_state = r_state; n_i = r_i; n_j = r_j; n_n = r_n;
        o_cmd = '0;
        o_cmd.idx = r_j;
        o_cmd.row = r_i;
        o_in_stall = (r_state != t_IDLE);
        case (r_state)
            t_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_spot = 1'b1;
                    n_n = w_n; n_i = IdxW'(1); n_state = t_DN_MUL;
                end
            end
            t_DN_MUL: begin
                o_cmd.mul_price = 1'b1; n_state = t_DN_RD;
            end
            t_DN_RD: begin
                o_cmd.dn_step = 1'b1;
                if (r_i == r_n) begin
                    n_j = '0; n_state = t_TM_RD;
                end else begin
                    n_i = r_i + 1'b1; n_state = t_DN_MUL;
                end
            end
            t_TM_RD: begin
                o_cmd.tm_start = (r_j == '0);
                o_cmd.tm_step = 1'b1;
                n_state = t_TM_MUL;
            end
            t_TM_MUL: begin
                o_cmd.mul_price = 1'b1;
                if (r_j == r_n) begin
                    n_i = r_n - 1'b1; n_j = '0; n_state = t_BK_RD;
                end else begin
                    n_j = r_j + 1'b1; n_state = t_TM_RD;
                end
            end
            t_BK_RD: begin
                o_cmd.bk_row = (r_j == '0);
                n_state = t_BK_MUL;
            end
            t_BK_MUL: begin
                o_cmd.mul_wt = 1'b1; n_state = t_BK_SUM;
            end
            t_BK_SUM: begin
                o_cmd.mul_price = 1'b1; n_state = t_BK_WR;
            end
            t_BK_WR: begin
                o_cmd.bk_write = 1'b1;
                if (r_j == r_i) begin
                    if (r_i == '0) n_state = t_DONE;
                    else begin
                        n_i = r_i - 1'b1; n_j = '0; n_state = t_BK_RD;
                    end
                end else begin
                    n_j = r_j + 1'b1; n_state = t_BK_RD;
                end
            end
            t_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.done = 1'b1; n_state = t_IDLE;
                end
            end
            default: n_state = t_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/blop_dp.sv =====
module blop_dp import blop_pkg::*; (
    input  logic        i_clk,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_spot,
    input  logic [31:0] i_strike,
    input  logic [31:0] i_down,
    input  logic [31:0] i_up_sq,
    input  logic [31:0] i_wu,
    input  logic [31:0] i_wd,
    input  logic        i_call,
    input  logic        i_amer,
    output logic [31:0] o_result
);
    logic [31:0] r_prices [MaxSteps+1];
    logic [31:0] r_values [MaxSteps+1];
    logic [31:0] r_price, r_pv, r_vup, r_vdn, r_root;
    logic [63:0] r_a, r_b;
    logic [31:0] w_fac, w_mp, w_ws, w_x, w_v;
    logic [63:0] w_hi, w_lo, w_prod;
    logic r_state_dn;

    function automatic logic [31:0] intr(input logic [31:0] p, input logic [31:0] k,
                                         input logic c);
        if (c) return (p > k) ? p - k : 32'd0;
        return (k > p) ? k - p : 32'd0;
    endfunction

    // dn: factor d; else u^2
    assign w_fac = (i_cmd.dn_step || r_state_dn) ? i_down : i_up_sq;
    assign w_prod = (64'(r_price) * 64'(w_fac) + (64'd1 << 29)) >> 30;
    assign w_mp = sat32(w_prod);
    assign w_hi = (r_a >> 31) + (r_b >> 31);
    assign w_lo = {33'd0, r_a[30:0]} + {33'd0, r_b[30:0]} + (64'd1 << 30);
    assign w_ws = sat32(w_hi + (w_lo >> 31));
    assign w_x = intr(r_price, i_strike, i_call);
    assign w_v = (i_amer && (w_x > w_ws)) ? w_x : w_ws;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_spot) begin
            r_price <= i_spot; r_prices[0] <= i_spot; r_state_dn <= 1'b1;
        end
        if (i_cmd.mul_price) r_pv <= w_mp;
        if (i_cmd.dn_step) begin
            r_prices[i_cmd.row] <= r_pv; r_price <= r_pv;
        end
        if (i_cmd.tm_step) begin
            r_state_dn <= 1'b0;
            if (!i_cmd.tm_start) r_price <= r_pv;
            r_values[i_cmd.idx] <= intr(i_cmd.tm_start ? r_price : r_pv, i_strike, i_call);
        end
        if (i_cmd.bk_row) r_price <= r_prices[i_cmd.row];
        if (!i_cmd.mul_wt && !i_cmd.mul_price && !i_cmd.bk_write) begin
            r_vup <= r_values[i_cmd.idx + 1'b1];
            r_vdn <= r_values[i_cmd.idx];
        end
        if (i_cmd.mul_wt) begin
            r_a <= 64'(i_wu) * 64'(r_vup);
            r_b <= 64'(i_wd) * 64'(r_vdn);
        end
        if (i_cmd.bk_write) begin
            r_values[i_cmd.idx] <= w_v;
            r_price <= r_pv;
            if (i_cmd.idx == '0) r_root <= w_v;
        end
    end
    assign o_result = r_root;
endmodule

// ===== hw/rtl/binomial_lattice_option_pricer_top.sv =====
// Throughput: one spot beat at a time, the next one accepted in the cycle after the result
// loads the output register; a node update steps through value read, weight multiply,
// price multiply and write back, with one multiplier pair for the weights.
// Reset: synchronous active-low; control, config and valid registers return to reset
// values, datapath registers and node arrays are not cleared (arrays written before read).
module binomial_lattice_option_pricer_top import blop_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_spot_price,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_option_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [31:0] r_strike, r_down, r_up_sq, r_wu, r_wd;
    logic [StepW-1:0] r_steps;
    logic r_call, r_amer, r_out_valid;
    logic [31:0] r_out, w_res;
    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strike <= '0; r_down <= 32'h4000_0000; r_up_sq <= 32'h4000_0000;
            r_wu <= 32'h4000_0000; r_wd <= 32'h4000_0000;
            r_steps <= StepW'(1); r_call <= 1'b1; r_amer <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegStrike: r_strike <= i_cfg_data;
                RegDown:   r_down   <= i_cfg_data;
                RegUpSq:   r_up_sq  <= i_cfg_data;
                RegWu:     r_wu     <= i_cfg_data;
                RegWd:     r_wd     <= i_cfg_data;
                RegSteps:  r_steps  <= i_cfg_data[StepW-1:0];
                RegCall:   r_call   <= i_cfg_data[0];
                RegAmer:   r_amer   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // output register; busy while an earlier result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_cmd.done) r_out_valid <= 1'b1;
        else if (!i_out_stall) r_out_valid <= 1'b0;
        if (w_cmd.done) r_out <= w_res;
    end

    blop_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_out_busy(r_out_valid && i_out_stall), .i_steps(r_steps),
        .o_in_stall(o_in_stall), .o_cmd(w_cmd)
    );

    blop_dp u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_spot(i_spot_price), .i_strike(r_strike),
        .i_down(r_down), .i_up_sq(r_up_sq), .i_wu(r_wu), .i_wd(r_wd),
        .i_call(r_call), .i_amer(r_amer), .o_result(w_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_option_value = r_out;
endmodule

// ===== verif/tb_binomial_lattice_option_pricer_top.sv =====
module tb_binomial_lattice_option_pricer_top;
    import blop_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_spot_price = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_option_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    binomial_lattice_option_pricer_top dut (.*);

    always #4 i_clk = ~i_clk;

    // Local copy of the pricer's register file.
    logic [31:0] strike_q;
    logic [31:0] down_q;
    logic [31:0] upsq_q;
    logic [31:0] wu_q;
    logic [31:0] wd_q;
    logic [7:0]  steps_q;
    logic        call_q;
    logic        amer_q;

    logic [31:0] value_queue[$];  // expected root values, oldest first
    int          n_errors = 0;
    int          hold_cycles = 0; // forced receiver hold-off, counted down by the receiver
    logic        rand_stall = 1'b1;

    // Short gaps mostly, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [31:0] price_mul(logic [31:0] p, logic [31:0] f);
        logic [63:0] prod;
        prod = 64'(p) * 64'(f) + (64'd1 << 29);
        prod = prod >> 30;
        return (prod[63:32] != 0) ? 32'hFFFF_FFFF : prod[31:0];
    endfunction

    function automatic logic [31:0] discounted_sum(logic [31:0] vu, logic [31:0] vd);
        logic [63:0] a, b, r;
        a = 64'(wu_q) * 64'(vu);
        b = 64'(wd_q) * 64'(vd);
        r = (a >> 31) + (b >> 31)
            + (((a & 64'h7FFF_FFFF) + (b & 64'h7FFF_FFFF) + (64'd1 << 30)) >> 31);
        return (r[63:32] != 0) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic logic [31:0] exercise_value(logic [31:0] px);
        if (call_q) return (px > strike_q) ? px - strike_q : 32'd0;
        return (strike_q > px) ? strike_q - px : 32'd0;
    endfunction

    // Backward induction over the binomial lattice.
    function automatic logic [31:0] lattice_value(logic [31:0] spot);
        logic [31:0] row_base[0:MaxSteps];
        logic [31:0] vals[0:MaxSteps];
        logic [31:0] px, v, x;
        int n;
        n = (steps_q == 0) ? 1 : (steps_q > MaxSteps) ? MaxSteps : int'(steps_q);
        row_base[0] = spot;
        for (int i = 1; i <= n; i++) row_base[i] = price_mul(row_base[i-1], down_q);
        px = row_base[n];
        for (int j = 0; j <= n; j++) begin
            vals[j] = exercise_value(px);
            px = price_mul(px, upsq_q);
        end
        for (int i = n - 1; i >= 0; i--) begin
            px = row_base[i];
            for (int j = 0; j <= i; j++) begin
                v = discounted_sum(vals[j+1], vals[j]);
                if (amer_q) begin
                    x = exercise_value(px);
                    if (x > v) v = x;
                end
                vals[j] = v;
                px = price_mul(px, upsq_q);
            end
        end
        return vals[0];
    endfunction

    // Valid stays up after the beat; load_params drops it after the last write.
    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            RegStrike: strike_q = data;
            RegDown:   down_q   = data;
            RegUpSq:   upsq_q   = data;
            RegWu:     wu_q     = data;
            RegWd:     wd_q     = data;
            RegSteps:  steps_q  = data[7:0];
            RegCall:   call_q   = data[0];
            RegAmer:   amer_q   = data[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // One spot beat; the expectation is queued at the accepting edge.
    // Valid stays up for a back-to-back beat; a gap or wait_idle drops it.
    task automatic send_spot(logic [31:0] spot, bit gaps = 1);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_spot_price <= spot;
        do @(posedge i_clk); while (o_in_stall);
        value_queue.push_back(lattice_value(spot));
        @(negedge i_clk);
    endtask

    // Drain, then let any in-flight work settle before touching registers.
    task automatic wait_idle();
        int t;
        t = 0;
        i_in_valid <= 1'b0;
        while (value_queue.size() != 0 && t < 2000000) begin
            @(negedge i_clk);
            t++;
        end
        repeat (40) @(negedge i_clk);
    endtask

    task automatic load_params(logic [31:0] k, logic [31:0] d, logic [31:0] u2,
                               logic [31:0] wu, logic [31:0] wd, logic [7:0] n,
                               logic c, logic am);
        wait_idle();
        cfg_write(RegStrike, k);
        cfg_write(RegDown, d);
        cfg_write(RegUpSq, u2);
        cfg_write(RegWu, wu);
        cfg_write(RegWd, wd);
        cfg_write(RegSteps, {24'(0), n});
        cfg_write(RegCall, {31'(0), c});
        cfg_write(RegAmer, {31'(0), am});
        i_cfg_valid <= 1'b0;
    endtask

    // Reset values, a zero spot, full scale and the lowest/highest bits.
    task automatic test_reset_defaults();
        send_spot(32'd0);
        send_spot(32'hFFFF_FFFF);
        send_spot(32'h0001_0000);
        send_spot(32'h8000_0001);
    endtask

    // Realistic European calls and puts and an American put, small trees.
    task automatic test_call_put_modes();
        load_params(32'h0064_0000, 32'h3E00_0000, 32'h4400_0000,
                    32'h4000_0000, 32'h3F00_0000, 8'd4, 1'b1, 1'b0);
        send_spot(32'h0064_0000);
        send_spot(32'h0050_8000);
        load_params(32'h0064_0000, 32'h3E00_0000, 32'h4400_0000,
                    32'h4000_0000, 32'h3F00_0000, 8'd5, 1'b0, 1'b1);
        send_spot(32'h0064_0000);
        send_spot(32'h0020_0000);
        load_params(32'h0064_0000, 32'h3E00_0000, 32'h4400_0000,
                    32'h4000_0000, 32'h3F00_0000, 8'd3, 1'b0, 1'b0);
        send_spot(32'h0070_0000);
    endtask

    // Steps of zero, above the maximum, and full-size trees.
    task automatic test_step_limits();
        load_params(32'h0010_0000, 32'h3F00_0000, 32'h4200_0000,
                    32'h4000_0000, 32'h3FF0_0000, 8'd0, 1'b1, 1'b1);
        send_spot(32'h0012_0000);
        load_params(32'h0010_0000, 32'h3FF0_0000, 32'h4020_0000,
                    32'h4000_0000, 32'h3FF0_0000, 8'd255, 1'b0, 1'b1);
        send_spot(32'h000F_0000);
        load_params(32'h0010_0000, 32'h3FF0_0000, 32'h4020_0000,
                    32'h4000_0000, 32'h3FF0_0000, 8'd128, 1'b1, 1'b0);
        send_spot(32'h0011_0000);
    endtask

    // Factors and weights no real model gives: all-ones (saturating) and all-zero values.
    task automatic test_saturation();
        load_params(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd6, 1'b1, 1'b1);
        send_spot(32'hFFFF_FFFF);
        send_spot(32'h0000_0001);
        load_params(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                    32'h0000_0000, 32'h0000_0000, 8'd2, 1'b0, 1'b0);
        send_spot(32'h1234_5678);
        load_params(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'h0000_0000, 8'd7, 1'b0, 1'b1);
        send_spot(32'hFFFF_FFFF);
    endtask

    // Random parameter sets, mostly sane and small, some wild or big.
    task automatic test_random_pricing();
        logic [31:0] d, u2;
        logic [7:0] n;
        for (int set = 0; set < 10; set++) begin
            if ($urandom_range(0, 4) == 0) begin
                d = $urandom(); u2 = $urandom();
            end else begin
                d = 32'h3C00_0000 + $urandom_range(0, 32'h0400_0000);
                u2 = 32'h4000_0000 + $urandom_range(0, 32'h0800_0000);
            end
            if (set == 4) n = 8'd128;
            else if ($urandom_range(0, 5) == 0) n = 8'($urandom());
            else n = 8'($urandom_range(1, 12));
            load_params($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0100_0000),
                        d, u2,
                        $urandom_range(0, 5) == 0 ? $urandom() : $urandom_range(0, 32'h4000_0000),
                        $urandom_range(0, 5) == 0 ? $urandom() : $urandom_range(0, 32'h4000_0000),
                        n, 1'($urandom()), 1'($urandom()));
            for (int k = 0; k < ((n > 20) ? 2 : 9); k++)
                send_spot($urandom_range(0, 2) == 0 ? $urandom()
                                                    : $urandom_range(0, 32'h0200_0000));
        end
    endtask

    // Receiver holds off while spots keep coming, so the input backs up.
    task automatic test_backpressure();
        load_params(32'h0008_0000, 32'h3F00_0000, 32'h4100_0000,
                    32'h3FF0_0000, 32'h3FF0_0000, 8'd2, 1'b1, 1'b0);
        hold_cycles = 400;
        for (int k = 0; k < 6; k++) send_spot($urandom_range(0, 32'h0010_0000), 0);
        wait_idle(); // sender pauses until everything is back
        for (int k = 0; k < 4; k++) send_spot($urandom());
    endtask

    // Receiver: random stalls, plus a forced hold-off when asked.
    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else if (!rand_stall) begin
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                g = gap_len() + 1;
                i_out_stall <= 1'b1;
                repeat (g) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Result checker, sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (value_queue.size() == 0) begin
                $error("option_value beat with nothing expected: actual %h", o_option_value);
                n_errors++;
            end else begin
                if (o_option_value !== value_queue[0]) begin
                    $error("option_value expected %h actual %h",
                           value_queue[0], o_option_value);
                    n_errors++;
                end
                void'(value_queue.pop_front());
            end
        end
    end

    initial begin
        strike_q = 32'd0;
        down_q = 32'h4000_0000;
        upsq_q = 32'h4000_0000;
        wu_q = 32'h4000_0000;
        wd_q = 32'h4000_0000;
        steps_q = 8'd1;
        call_q = 1'b1;
        amer_q = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_call_put_modes();
        test_step_limits();
        test_saturation();
        test_random_pricing();
        test_backpressure();
        wait_idle();
        if (n_errors == 0 && value_queue.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    // Timeout covering several full-size trees, plus stalls and gaps.
    initial begin
        #(8 * 3000000);
        $display("FAIL");
        $finish;
    end
endmodule

// ===== binomial_lattice_option_pricer_top.f =====
hw/rtl/blop_pkg.sv
hw/rtl/blop_ctrl.sv
hw/rtl/blop_dp.sv
hw/rtl/binomial_lattice_option_pricer_top.sv
verif/tb_binomial_lattice_option_pricer_top.sv
